// ===== rtl/kpsr_pkg.sv =====
// Shared types, constants and the key decode function for the keypad scan block.
// Used by kpsr_core and keypad_scan_with_auto_repeat; depends on nothing.

`default_nettype none

package kpsr_pkg;

    localparam int unsigned KEY_W       = 14;
    localparam int unsigned LINES_W     = 10;
    localparam int unsigned EXTRA_W     = 16;
    localparam int unsigned CNT_W       = 8;
    localparam int unsigned CFG_INDEX_W = 2;

    // Keys that exist after decode: bit 12 is never a key.
    localparam logic [KEY_W-1:0] KEY_MASK = 14'h2FFF;

    localparam int unsigned LID_BIT   = 15;
    localparam int unsigned RIGHT_BIT = 4;
    localparam int unsigned LEFT_BIT  = 5;
    localparam int unsigned UP_BIT    = 6;
    localparam int unsigned DOWN_BIT  = 7;

    localparam logic [CNT_W-1:0] RATE_RESET  = 8'd8;
    localparam logic [CNT_W-1:0] DELAY_RESET = 8'd15;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_RATE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_DELAY = 2'd1;

    typedef struct packed {
        logic [LINES_W-1:0] key_lines;
        logic [EXTRA_W-1:0] extra_lines;
        logic               frame_parity;
    } frame_t;

    typedef struct packed {
        logic [KEY_W-1:0] held_now;
        logic [KEY_W-1:0] pressed_now;
        logic [KEY_W-1:0] repeat_now;
        logic [KEY_W-1:0] held_latched;
        logic [KEY_W-1:0] pressed_latched;
        logic [KEY_W-1:0] repeat_latched;
    } result_t;

    // Invert the active-low lines, mask, then let up beat down and left beat right.
    function automatic logic [KEY_W-1:0] key_decode(
        input logic [LINES_W-1:0] lines,
        input logic [EXTRA_W-1:0] extra
    );
        logic [KEY_W-1:0] raw;
        logic [KEY_W-1:0] keys;
        raw  = {{(KEY_W-LINES_W){1'b0}}, lines} | extra[KEY_W-1:0];
        keys = ~raw & KEY_MASK;
        keys[DOWN_BIT]  = keys[DOWN_BIT] & ~keys[UP_BIT];
        keys[RIGHT_BIT] = keys[RIGHT_BIT] & ~keys[LEFT_BIT];
        return keys;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/kpsr_core.sv =====
// Frame processing for the keypad scan: edge detect, auto-repeat countdown and
// two-frame accumulators with their hold registers. Depends on kpsr_pkg.

`default_nettype none

module kpsr_core
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         step,
    input  wire kpsr_pkg::frame_t             frame,
    input  wire logic [kpsr_pkg::CNT_W-1:0]   repeat_rate,
    input  wire logic [kpsr_pkg::CNT_W-1:0]   repeat_delay,
    output kpsr_pkg::result_t                 result
);

    logic [kpsr_pkg::KEY_W-1:0] prev_keys_reg,   prev_keys_next;
    logic [kpsr_pkg::CNT_W-1:0] countdown_reg,   countdown_next;
    logic [kpsr_pkg::KEY_W-1:0] held_acc_reg,    held_acc_next;
    logic [kpsr_pkg::KEY_W-1:0] pressed_acc_reg, pressed_acc_next;
    logic [kpsr_pkg::KEY_W-1:0] repeat_acc_reg,  repeat_acc_next;
    logic [kpsr_pkg::KEY_W-1:0] held_hold_reg,   held_hold_next;
    logic [kpsr_pkg::KEY_W-1:0] pressed_hold_reg, pressed_hold_next;
    logic [kpsr_pkg::KEY_W-1:0] repeat_hold_reg, repeat_hold_next;

    logic [kpsr_pkg::KEY_W-1:0] keys;
    logic [kpsr_pkg::KEY_W-1:0] pressed;
    logic [kpsr_pkg::KEY_W-1:0] repeats;
    logic [kpsr_pkg::CNT_W-1:0] count_dec;
    logic [kpsr_pkg::KEY_W-1:0] held_or;
    logic [kpsr_pkg::KEY_W-1:0] pressed_or;
    logic [kpsr_pkg::KEY_W-1:0] repeat_or;
    logic                       lid_closed;

    always_comb
    begin
        lid_closed = frame.extra_lines[kpsr_pkg::LID_BIT];
        keys       = kpsr_pkg::key_decode(frame.key_lines, frame.extra_lines);
        pressed    = keys & ~prev_keys_reg;
        repeats    = pressed;
        count_dec  = countdown_reg - 8'd1;

        prev_keys_next    = prev_keys_reg;
        countdown_next    = countdown_reg;
        held_acc_next     = held_acc_reg;
        pressed_acc_next  = pressed_acc_reg;
        repeat_acc_next   = repeat_acc_reg;
        held_hold_next    = held_hold_reg;
        pressed_hold_next = pressed_hold_reg;
        repeat_hold_next  = repeat_hold_reg;

        // Unchanged non-empty combination counts down; expiry repeats every held key
        if ((keys != '0) && (keys == prev_keys_reg))
        begin
            if (count_dec == '0)
            begin
                repeats = keys;
                countdown_next = repeat_rate;
            end
            else
            begin
                countdown_next = count_dec;
            end
        end
        else
        begin
            countdown_next = repeat_delay;
        end

        held_or    = held_acc_reg | keys;
        pressed_or = pressed_acc_reg | pressed;
        repeat_or  = repeat_acc_reg | repeats;

        if (lid_closed)
        begin
            // Lid closed: drop the holds, keep everything else
            countdown_next    = countdown_reg;
            held_hold_next    = '0;
            pressed_hold_next = '0;
            repeat_hold_next  = '0;
        end
        else
        begin
            prev_keys_next = keys;
            if (!frame.frame_parity)
            begin
                held_hold_next    = held_or;
                pressed_hold_next = pressed_or;
                repeat_hold_next  = repeat_or;
                held_acc_next     = '0;
                pressed_acc_next  = '0;
                repeat_acc_next   = '0;
            end
            else
            begin
                held_acc_next    = held_or;
                pressed_acc_next = pressed_or;
                repeat_acc_next  = repeat_or;
            end
        end

        if (lid_closed)
        begin
            result = '0;
        end
        else
        begin
            result.held_now        = keys;
            result.pressed_now     = pressed;
            result.repeat_now      = repeats;
            result.held_latched    = held_hold_next;
            result.pressed_latched = pressed_hold_next;
            result.repeat_latched  = repeat_hold_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_keys_reg    <= '0;
            countdown_reg    <= '0;
            held_acc_reg     <= '0;
            pressed_acc_reg  <= '0;
            repeat_acc_reg   <= '0;
            held_hold_reg    <= '0;
            pressed_hold_reg <= '0;
            repeat_hold_reg  <= '0;
        end
        else if (step)
        begin
            prev_keys_reg    <= prev_keys_next;
            countdown_reg    <= countdown_next;
            held_acc_reg     <= held_acc_next;
            pressed_acc_reg  <= pressed_acc_next;
            repeat_acc_reg   <= repeat_acc_next;
            held_hold_reg    <= held_hold_next;
            pressed_hold_reg <= pressed_hold_next;
            repeat_hold_reg  <= repeat_hold_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/keypad_scan_with_auto_repeat.sv =====
// Top level of the keypad scan block with edge detection and auto repeat.
// Depends on kpsr_pkg and kpsr_core.
//
// Use:
//   Input channel (in_valid/in_ready): one transaction is one scan frame,
//   carrying key_lines, extra_lines and frame_parity.
//   Output channel (out_valid/out_ready): one transaction per frame, carrying
//   the three per-frame key sets and the three latched sets.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0
//   is the repeat rate, index 1 the repeat delay; other indexes are ignored.
//   cfg_ready is always high. Write only while the block is idle.
// Timing:
//   A frame is captured in an input register, processed by one level of
//   shallow logic and captured in the result register, which drives out_valid
//   and the result outputs. One frame is accepted every cycle while the
//   output side keeps up; the rate is set by the single result register stage.
// Reset:
//   rst_n clears both pipeline valid flags, all key state, accumulators and
//   hold registers, and loads rate 8 and delay 15.
// Stall:
//   While out_ready is low the result holds; one further frame may wait in
//   the input register, after which in_ready drops until the result is taken.

`default_nettype none

module keypad_scan_with_auto_repeat
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [kpsr_pkg::LINES_W-1:0]       key_lines,
    input  wire logic [kpsr_pkg::EXTRA_W-1:0]       extra_lines,
    input  wire logic                               frame_parity,

    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [kpsr_pkg::KEY_W-1:0]              held_now,
    output logic [kpsr_pkg::KEY_W-1:0]              pressed_now,
    output logic [kpsr_pkg::KEY_W-1:0]              repeat_now,
    output logic [kpsr_pkg::KEY_W-1:0]              held_latched,
    output logic [kpsr_pkg::KEY_W-1:0]              pressed_latched,
    output logic [kpsr_pkg::KEY_W-1:0]              repeat_latched,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [kpsr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [kpsr_pkg::CNT_W-1:0]         cfg_data
);

    // Configuration registers
    logic [kpsr_pkg::CNT_W-1:0] rate_reg,  rate_next;
    logic [kpsr_pkg::CNT_W-1:0] delay_reg, delay_next;

    // Input register stage
    logic                       s1_valid_reg, s1_valid_next;
    kpsr_pkg::frame_t           s1_frame_reg;

    // Result register stage
    logic                       out_valid_reg, out_valid_next;
    kpsr_pkg::result_t          out_result_reg;
    kpsr_pkg::result_t          core_result;

    logic                       advance;
    logic                       step;
    logic                       in_accept;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        rate_next  = rate_reg;
        delay_next = delay_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                kpsr_pkg::CFG_REPEAT_RATE:  rate_next  = cfg_data;
                kpsr_pkg::CFG_REPEAT_DELAY: delay_next = cfg_data;
                default:                    ; // unknown index: ignore the write
            endcase
        end
    end

    // Advance the whole pipe whenever the result register is free or being taken
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || advance;
    assign in_accept = in_valid && in_ready;
    assign step      = s1_valid_reg && advance;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
        end
        if (in_ready)
        begin
            s1_valid_next = in_valid;
        end
    end

    kpsr_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .frame        (s1_frame_reg),
        .repeat_rate  (rate_reg),
        .repeat_delay (delay_reg),
        .result       (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= kpsr_pkg::RATE_RESET;
            delay_reg     <= kpsr_pkg::DELAY_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rate_reg      <= rate_next;
            delay_reg     <= delay_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: no reset, qualified by their valid flags
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_frame_reg.key_lines    <= key_lines;
            s1_frame_reg.extra_lines  <= extra_lines;
            s1_frame_reg.frame_parity <= frame_parity;
        end
        if (step)
        begin
            out_result_reg <= core_result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign held_now        = out_result_reg.held_now;
    assign pressed_now     = out_result_reg.pressed_now;
    assign repeat_now      = out_result_reg.repeat_now;
    assign held_latched    = out_result_reg.held_latched;
    assign pressed_latched = out_result_reg.pressed_latched;
    assign repeat_latched  = out_result_reg.repeat_latched;

    // New presses and repeats are always a subset of the held set
    a_subset_now: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (((pressed_now | repeat_now) & ~held_now) == '0))
        else $error("pressed or repeat key not held");

    // Direction suppression and the unused key position
    a_suppress: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!(held_now[kpsr_pkg::UP_BIT] && held_now[kpsr_pkg::DOWN_BIT])
                       && !(held_now[kpsr_pkg::LEFT_BIT] && held_now[kpsr_pkg::RIGHT_BIT])
                       && !held_now[12]))
        else $error("suppressed or masked key reported as held");

    // Latched presses can only come from keys latched as held
    a_subset_latched: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((pressed_latched & ~held_latched) == '0))
        else $error("latched press without latched hold");

    // A waiting frame must move on when the result stage advances
    a_pipe_move: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance && !in_valid) |=> (out_valid_reg && !s1_valid_reg))
        else $error("input stage failed to advance");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for keypad_scan_with_auto_repeat: a directed frame table and then random
// key gestures under several repeat settings, checked by an in-bench predictor or typed rows.
// Depends on kpsr_pkg and the keypad_scan_with_auto_repeat RTL.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kpsr_pkg::*;

    // Pipeline allowance covering the input register and the result register
    localparam int PIPE_LAT        = 2;
    localparam int IDLE_PCT        = 26;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int MAX_REPORTS     = 10;
    localparam int N_PHASES        = 6;

    // Indexes past the register list; writes to them must change nothing
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam logic [KEY_W-1:0] UP_KEY   = 14'h0040;
    localparam logic [KEY_W-1:0] LEFT_KEY = 14'h0020;
    // Every key down at once: up beats down, left beats right
    localparam logic [KEY_W-1:0] ALL_KEYS = 14'h2F6F;

    // Phase 0 runs on the reset values, the last phase draws its own settings
    localparam int PHASE_RATE  [N_PHASES] = '{8, 1, 255, 0, 3, 0};
    localparam int PHASE_DELAY [N_PHASES] = '{15, 1, 255, 0, 200, 0};
    localparam int PHASE_ITEMS [N_PHASES] = '{200, 200, 400, 350, 250, 300};
    localparam int PHASE_HOLD  [N_PHASES] = '{40, 20, 560, 560, 240, 60};

    typedef struct {
        logic [LINES_W-1:0] lines;
        logic [EXTRA_W-1:0] extra;
        logic               parity;
        bit                 known;
        result_t            want;
    } scan_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [LINES_W-1:0]     key_lines;
    logic [EXTRA_W-1:0]     extra_lines;
    logic                   frame_parity;
    logic                   out_valid;
    logic                   out_ready;
    logic [KEY_W-1:0]       held_now;
    logic [KEY_W-1:0]       pressed_now;
    logic [KEY_W-1:0]       repeat_now;
    logic [KEY_W-1:0]       held_latched;
    logic [KEY_W-1:0]       pressed_latched;
    logic [KEY_W-1:0]       repeat_latched;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CNT_W-1:0]       cfg_data;

    // Predictor copy of the block's registers, starting from their reset values
    logic [CNT_W-1:0] cur_rate     = RATE_RESET;
    logic [CNT_W-1:0] cur_delay    = DELAY_RESET;
    logic [KEY_W-1:0] prev_keys    = '0;
    logic [CNT_W-1:0] rpt_count    = '0;
    logic [KEY_W-1:0] acc_held     = '0;
    logic [KEY_W-1:0] acc_pressed  = '0;
    logic [KEY_W-1:0] acc_repeat   = '0;
    logic [KEY_W-1:0] hold_held    = '0;
    logic [KEY_W-1:0] hold_pressed = '0;
    logic [KEY_W-1:0] hold_repeat  = '0;

    result_t   results_due[$];
    scan_row_t directed_rows[$];

    int cycle_count    = 0;
    int mismatch_count = 0;
    bit calm           = 1'b0;
    bit hold_off_req   = 1'b0;
    bit frame_toggle   = 1'b0;

    keypad_scan_with_auto_repeat dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .key_lines       (key_lines),
        .extra_lines     (extra_lines),
        .frame_parity    (frame_parity),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .held_now        (held_now),
        .pressed_now     (pressed_now),
        .repeat_now      (repeat_now),
        .held_latched    (held_latched),
        .pressed_latched (pressed_latched),
        .repeat_latched  (repeat_latched),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: fail and end the run once the cycle count passes the limit
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("keypad_scan_with_auto_repeat verification failed");
            $finish;
        end
    end

    // Work out one frame's result and advance the predictor state.
    task automatic decode_frame(input logic [LINES_W-1:0] lines, input logic [EXTRA_W-1:0] extra,
                                input logic parity, output result_t r);
        logic [EXTRA_W-1:0] merged;
        logic [KEY_W-1:0]   keys;
        logic [KEY_W-1:0]   fresh;
        logic [KEY_W-1:0]   rpt;
        if (extra[LID_BIT])
        begin
            // Lid shut: blank the outputs and the hold registers, keep the rest
            hold_held    = '0;
            hold_pressed = '0;
            hold_repeat  = '0;
            r            = '0;
        end
        else
        begin
            // A key counts only when all of its lines are pulled low
            merged = {{(EXTRA_W-LINES_W){1'b0}}, lines} | extra;
            keys   = (merged[KEY_W-1:0] ^ KEY_MASK) & KEY_MASK;
            keys   = keys & ~((keys & UP_KEY) << 1) & ~((keys & LEFT_KEY) >> 1);
            fresh  = keys & ~prev_keys;
            rpt    = fresh;
            // Count down only while the same non-empty set stays down;
            // a count of zero wraps round to the top
            if (keys != '0 && keys == prev_keys)
            begin
                rpt_count = rpt_count - 1'b1;
                if (rpt_count == '0)
                begin
                    rpt       = keys;
                    rpt_count = cur_rate;
                end
            end
            else
                rpt_count = cur_delay;
            prev_keys   = keys;
            acc_held    = acc_held | keys;
            acc_pressed = acc_pressed | fresh;
            acc_repeat  = acc_repeat | rpt;
            // Even frame: latch the two-frame sets and start afresh
            if (!parity)
            begin
                hold_held    = acc_held;
                hold_pressed = acc_pressed;
                hold_repeat  = acc_repeat;
                acc_held     = '0;
                acc_pressed  = '0;
                acc_repeat   = '0;
            end
            r.held_now        = keys;
            r.pressed_now     = fresh;
            r.repeat_now      = rpt;
            r.held_latched    = hold_held;
            r.pressed_latched = hold_pressed;
            r.repeat_latched  = hold_repeat;
        end
    endtask

    task automatic add_row(input logic [LINES_W-1:0] lines, input logic [EXTRA_W-1:0] extra,
                           input logic parity, input bit known, input result_t want);
        scan_row_t row;
        row.lines  = lines;
        row.extra  = extra;
        row.parity = parity;
        row.known  = known;
        row.want   = want;
        directed_rows.push_back(row);
    endtask

    // Offer one frame transaction, after a random gap, and hold it until accepted.
    task automatic send_frame(input logic [LINES_W-1:0] lines, input logic [EXTRA_W-1:0] extra,
                              input logic parity, input bit known, input result_t want);
        result_t predicted;
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        key_lines    = lines;
        extra_lines  = extra;
        frame_parity = parity;
        in_valid     = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // Run the predictor even on typed rows so that its state stays in step
        decode_frame(lines, extra, parity, predicted);
        results_due.push_back(known ? want : predicted);
    endtask

    // Drop valid, wait for every outstanding result, then let the pipeline settle.
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [CNT_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (index == CFG_REPEAT_RATE)
            cur_rate = data;
        else if (index == CFG_REPEAT_DELAY)
            cur_delay = data;
    endtask

    // Random key gestures: mostly a key set held for a run of frames with alternating
    // parity, so that the repeat countdown gets exercised, plus raw noise and flicker.
    task automatic run_gestures(input int count, input int max_hold);
        int               sent;
        int               len;
        int               mode;
        int               k;
        bit               stalled;
        bit               broken;
        logic [31:0]      noise;
        logic [KEY_W-1:0] press;
        logic [LINES_W-1:0] lines;
        logic [EXTRA_W-1:0] extra;
        logic             parity;
        sent    = 0;
        stalled = 1'b0;
        while (sent < count)
        begin
            mode = $urandom_range(0, 99);
            if (mode < 15)
                len = 1;
            else if ($urandom_range(0, 3) == 0)
                len = $urandom_range(max_hold / 2, max_hold);
            else
                len = $urandom_range(1, 12);
            broken = (mode >= 15 && mode < 30);
            case ($urandom_range(0, 2))
                0:       press = (14'd1 << $urandom_range(0, 13))
                               | (14'd1 << $urandom_range(0, 13));
                1:       press = (KEY_W'($urandom) & 14'h00F0) | (14'd1 << $urandom_range(0, 13));
                default: press = KEY_W'($urandom);
            endcase
            for (k = 0; k < len && sent < count; k++)
            begin
                // Halfway through, make the receiver hold off while frames keep coming
                if (!stalled && sent >= count / 2)
                begin
                    hold_off_req = 1'b1;
                    stalled      = 1'b1;
                end
                noise = $urandom;
                if (mode < 15)
                begin
                    lines  = LINES_W'(noise);
                    extra  = EXTRA_W'($urandom);
                    parity = noise[31];
                end
                else
                begin
                    // Pull both lines of each pressed key low; keep every other key open
                    // on at least one of its lines, and toss the ignored bits
                    extra = {1'b0, noise[21], ~press[13], noise[20], ~press[11:10],
                             noise[9:0] & ~press[9:0]};
                    lines = ~press[9:0] & (~extra[9:0] | noise[19:10]);
                    if (broken && $urandom_range(0, 9) == 0)
                        lines = lines ^ (LINES_W'(1) << $urandom_range(0, LINES_W - 1));
                    if ($urandom_range(0, 24) == 0)
                        extra[LID_BIT] = 1'b1;
                    parity = frame_toggle;
                    if ($urandom_range(0, 29) == 0)
                        parity = ~parity;
                end
                send_frame(lines, extra, parity, 1'b0, '0);
                frame_toggle = ~frame_toggle;
                sent++;
            end
        end
    endtask

    // Receiver: random back-pressure, or one long hold-off when asked for
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
                hold_off_req = 1'b0;
            end
            else
                out_ready = calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Checker: compare every result transaction with the oldest expectation
    always @(posedge clk)
    begin
        result_t seen;
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen.held_now        = held_now;
            seen.pressed_now     = pressed_now;
            seen.repeat_now      = repeat_now;
            seen.held_latched    = held_latched;
            seen.pressed_latched = pressed_latched;
            seen.repeat_latched  = repeat_latched;
            if (results_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("cycle %0d: result with nothing expected: %h %h %h %h %h %h",
                             cycle_count, seen.held_now, seen.pressed_now, seen.repeat_now,
                             seen.held_latched, seen.pressed_latched, seen.repeat_latched);
            end
            else
            begin
                want = results_due.pop_front();
                if (seen !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("cycle %0d: expected %h %h %h %h %h %h got %h %h %h %h %h %h",
                                 cycle_count, want.held_now, want.pressed_now,
                                 want.repeat_now, want.held_latched, want.pressed_latched,
                                 want.repeat_latched, seen.held_now, seen.pressed_now,
                                 seen.repeat_now, seen.held_latched, seen.pressed_latched,
                                 seen.repeat_latched);
                end
            end
        end
    end

    // Stimulus: reset, the directed table on the reset settings, then one random
    // phase per repeat setting, rewriting the registers only while the block is idle
    initial
    begin
        int      phase;
        logic [CNT_W-1:0] rate;
        logic [CNT_W-1:0] delay;
        result_t first_all;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        key_lines    = '1;
        extra_lines  = 16'h7FFF;
        frame_parity = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_REPEAT_RATE;
        cfg_data     = '0;

        first_all = {ALL_KEYS, ALL_KEYS, ALL_KEYS, {(3*KEY_W){1'b0}}};

        // Nothing pressed, lid shut, then every key down on an odd frame
        add_row(10'h3FF, 16'h7FFF, 1'b0, 1'b1, '0);
        add_row(10'h3FF, 16'hFFFF, 1'b1, 1'b1, '0);
        add_row(10'h000, 16'h0000, 1'b1, 1'b1, first_all);
        add_row(10'h000, 16'h0000, 1'b0, 1'b0, '0);
        // Lid shut with keys down still blanks everything
        add_row(10'h000, 16'h8000, 1'b0, 1'b1, '0);
        add_row(10'h3FF, 16'h7FFF, 1'b1, 1'b0, '0);
        // Directions alone and in the suppressing pairs
        add_row(10'h37F, 16'h7F7F, 1'b0, 1'b0, '0);
        add_row(10'h33F, 16'h7F3F, 1'b1, 1'b0, '0);
        add_row(10'h3EF, 16'h7FEF, 1'b0, 1'b0, '0);
        add_row(10'h3CF, 16'h7FCF, 1'b1, 1'b0, '0);
        // Extra keys, then only the bits outside the key mask low
        add_row(10'h3FF, 16'h53FF, 1'b0, 1'b0, '0);
        add_row(10'h3FF, 16'h2FFF, 1'b1, 1'b0, '0);
        add_row(10'h000, 16'h7C00, 1'b0, 1'b0, '0);
        add_row(10'h000, 16'hFFFF, 1'b1, 1'b0, '0);
        // Hold the extra keys across several odd and even frames
        add_row(10'h3FF, 16'h0000, 1'b0, 1'b0, '0);
        add_row(10'h3FF, 16'h0000, 1'b1, 1'b0, '0);
        add_row(10'h3FF, 16'h0000, 1'b1, 1'b0, '0);
        add_row(10'h3FF, 16'h0000, 1'b0, 1'b0, '0);
        add_row(10'h2AA, 16'h5555, 1'b0, 1'b0, '0);
        add_row(10'h155, 16'h2AAA, 1'b1, 1'b0, '0);
        add_row(10'h3FF, 16'h7FFF, 1'b0, 1'b0, '0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_frame(directed_rows[i].lines, directed_rows[i].extra,
                       directed_rows[i].parity, directed_rows[i].known, directed_rows[i].want);

        for (phase = 0; phase < N_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                // Sender pauses here until every expected result has come back
                drain_results();
                if (phase == N_PHASES - 1)
                begin
                    rate  = CNT_W'($urandom_range(1, 255));
                    delay = CNT_W'($urandom_range(1, 255));
                end
                else
                begin
                    rate  = CNT_W'(PHASE_RATE[phase]);
                    delay = CNT_W'(PHASE_DELAY[phase]);
                end
                write_reg(CFG_SPARE_A, CNT_W'($urandom));
                write_reg(CFG_REPEAT_RATE, rate);
                write_reg(CFG_REPEAT_DELAY, delay);
                write_reg(CFG_SPARE_B, CNT_W'($urandom));
                @(negedge clk);
                cfg_valid = 1'b0;
            end
            // Run the fastest setting with no idling on either side
            calm = (phase == 1);
            run_gestures(PHASE_ITEMS[phase], PHASE_HOLD[phase]);
        end
        calm = 1'b0;

        drain_results();
        if (mismatch_count == 0 && results_due.size() == 0)
            $display("keypad_scan_with_auto_repeat verification clean");
        else
            $display("keypad_scan_with_auto_repeat verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/kpsr_pkg.sv
rtl/kpsr_core.sv
rtl/keypad_scan_with_auto_repeat.sv
bench/tb_top.sv
